// File: src/i8cv_pkg.sv
// Package for the int8 1-D convolution core: sizes, request codes,
// configuration indexes, payload structs and size clamping helpers.
// Depends on nothing.
package i8cv_pkg;

    localparam int MAX_CHANNELS_IN  = 16;
    localparam int MAX_CHANNELS_OUT = 16;
    localparam int MAX_TAPS         = 8;
    localparam int W_DEPTH          = MAX_CHANNELS_OUT * MAX_CHANNELS_IN * MAX_TAPS;
    localparam int W_AW             = $clog2(W_DEPTH);
    localparam int CH_W             = $clog2(MAX_CHANNELS_IN);
    localparam int TAP_W            = $clog2(MAX_TAPS);
    localparam int F_W              = $clog2(MAX_CHANNELS_OUT);

    localparam logic [1:0] ACT_LOAD_W = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_DATA   = 2'd2;
    localparam logic [1:0] ACT_NEWSEQ = 2'd3;

    localparam logic [2:0] CFG_CIN   = 3'd0;
    localparam logic [2:0] CFG_COUT  = 3'd1;
    localparam logic [2:0] CFG_K     = 3'd2;
    localparam logic [2:0] CFG_MULT  = 3'd3;
    localparam logic [2:0] CFG_SHIFT = 3'd4;
    localparam logic [2:0] CFG_BIAS  = 3'd5;
    localparam logic [2:0] CFG_MASK  = 3'd6;

    typedef struct packed {
        logic [1:0]         action;
        logic [10:0]        weight_index;
        logic signed [7:0]  weight_value;
        logic               mask_bit;
        logic [3:0]         bias_index;
        logic signed [31:0] bias_value;
        logic signed [7:0]  activation;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] out_value;
        logic [3:0]        filter_index;
        logic              last_of_row;
    } t_out_item;

    typedef logic [MAX_CHANNELS_IN-1:0][7:0] t_row;

    // Sizes of zero act as one and sizes above the maximum act as the maximum.
    function automatic logic [4:0] clamp5(input logic [4:0] v, input logic [4:0] hi);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [3:0] clamp4(input logic [3:0] v, input logic [3:0] hi);
        logic [3:0] r;
        if (v == 4'd0) begin
            r = 4'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: src/int8_conv1d_requant_masked_core.sv
// Top level of the int8 1-D convolution core with prune mask and requantization.
// Depends on i8cv_pkg, i8cv_ram and i8cv_row_cell.
//
// Usage: configuration writes arrive on the cfg channel (index, data), always
// ready, and must be made while the core is idle; the core does not enforce
// this. Input requests load a weight with its mask bit, load a bias, restart
// the sequence, or deliver one activation. Loads and activations that do not
// complete a row leave the core idle and may follow back to back. A restart
// also rotates the row ring back to its home position, which keeps the input
// busy while it rotates. A row that completes before kernel_len rows are held
// rotates the ring once, through S_ROT, before the input is ready again.
// When a row completes and kernel_len rows are held, the core emits one result
// per filter. Each filter runs Cin*K multiply-accumulate steps, one weight
// read from the weight RAM per cycle, then drain and requantization through
// S_WAIT, S_MUL, S_RND and S_SAT, and an output state. Only one request is
// worked on at a time: the input is not ready until all results are taken. A
// result is held on o_out until i_out_ready; the receiver may stall.
// Reset clears the sequence counters and restores the register defaults; the
// weight, bias and row stores hold no defined value until written.
module int8_conv1d_requant_masked_core
    import i8cv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_SAT  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_ROT  = 3'd7;

    logic [4:0]  r_cin_cfg, r_cout_cfg;
    logic [3:0]  r_k_cfg;
    logic [30:0] r_mult;
    logic [5:0]  r_shift;
    logic        r_use_bias, r_use_mask;

    logic [31:0] r_bias [MAX_CHANNELS_OUT];

    logic [2:0]       r_state;
    logic [CH_W-1:0]  r_ch;
    logic [3:0]       r_rows;
    logic [TAP_W-1:0] r_head;
    logic             r_realign;
    logic [F_W-1:0]   r_f;
    logic [CH_W-1:0]  r_c;
    logic [TAP_W-1:0] r_t;
    logic [W_AW-1:0]  r_addr;
    logic             r_p_vld;
    logic signed [7:0] r_p_x;
    logic [31:0]      r_acc;
    logic             r_neg;
    logic [62:0]      r_prod;
    logic [62:0]      r_sum;
    t_out_item        r_out;

    logic [4:0] cin, cout;
    logic [3:0] k;
    logic       in_acc, data_acc;
    logic [4:0] n_count;
    logic [3:0] n_rows;
    logic       t_end, c_end, f_end;
    logic [3:0] tap_age;
    logic [8:0] w_rdata;
    logic signed [15:0] prod;
    logic [31:0] mag;
    logic [62:0] rnd, p;
    logic [7:0]  sat;

    t_row       cell_row [MAX_TAPS];
    logic [7:0] cell_rd  [MAX_TAPS];

    assign cin  = clamp5(r_cin_cfg, 5'(MAX_CHANNELS_IN));
    assign cout = clamp5(r_cout_cfg, 5'(MAX_CHANNELS_OUT));
    assign k    = clamp4(r_k_cfg, 4'(MAX_TAPS));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc   = i_in_valid && o_in_ready;
    assign data_acc = in_acc && (i_in.action == ACT_DATA);
    assign n_count  = {1'b0, r_ch} + 5'd1;
    assign n_rows   = (r_rows < k) ? r_rows + 4'd1 : k;

    assign t_end   = ({1'b0, r_t} == k - 4'd1);
    assign c_end   = ({1'b0, r_c} == cin - 5'd1);
    assign f_end   = ({1'b0, r_f} == cout - 5'd1);
    assign tap_age = k - 4'd1 - {1'b0, r_t};

    i8cv_ram #(.P_WIDTH(9), .P_DEPTH(W_DEPTH)) u_wram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_in.action == ACT_LOAD_W)),
        .i_waddr (i_in.weight_index),
        .i_wdata ({i_in.mask_bit, i_in.weight_value}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        i8cv_row_cell u_cell (
            .i_clk     (i_clk),
            .i_wr_en   ((j == 0) && data_acc),
            .i_wr_ch   (r_ch),
            .i_wr_data (i_in.activation),
            .i_shift   (r_state == S_ROT),
            .i_row     (cell_row[(j + MAX_TAPS - 1) % MAX_TAPS]),
            .i_rd_ch   (r_c),
            .o_row     (cell_row[j]),
            .o_rd      (cell_rd[j])
        );
    end

    assign prod = $signed(w_rdata[7:0]) * r_p_x;
    assign mag  = r_acc[31] ? (~r_acc + 32'd1) : r_acc;
    assign rnd  = (r_shift != 6'd0) ? (63'd1 << (r_shift - 6'd1)) : 63'd0;
    assign p    = r_sum >> r_shift;

    always_comb begin
        if (r_neg) begin
            sat = (p > 63'd128) ? 8'h80 : (~p[7:0] + 8'd1);
        end else begin
            sat = (p > 63'd127) ? 8'h7F : p[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cin_cfg  <= 5'd1;
            r_cout_cfg <= 5'd1;
            r_k_cfg    <= 4'd1;
            r_mult     <= 31'd1073741824;
            r_shift    <= 6'd30;
            r_use_bias <= 1'b0;
            r_use_mask <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CIN:   r_cin_cfg  <= i_cfg_data[4:0];
                CFG_COUT:  r_cout_cfg <= i_cfg_data[4:0];
                CFG_K:     r_k_cfg    <= i_cfg_data[3:0];
                CFG_MULT:  r_mult     <= i_cfg_data[30:0];
                CFG_SHIFT: r_shift    <= i_cfg_data[5:0];
                CFG_BIAS:  r_use_bias <= i_cfg_data[0];
                CFG_MASK:  r_use_mask <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.action == ACT_LOAD_B)) begin
            r_bias[i_in.bias_index] <= i_in.bias_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ch      <= '0;
            r_rows    <= '0;
            r_head    <= '0;
            r_realign <= 1'b0;
            r_p_vld   <= 1'b0;
        end else begin
            r_p_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in.action == ACT_NEWSEQ)) begin
                        r_ch   <= '0;
                        r_rows <= '0;
                        if (r_head != '0) begin
                            r_realign <= 1'b1;
                            r_state   <= S_ROT;
                        end
                    end else if (data_acc) begin
                        if (n_count < cin) begin
                            r_ch <= n_count[CH_W-1:0];
                        end else begin
                            r_ch   <= '0;
                            r_rows <= n_rows;
                            r_state <= (n_rows >= k) ? S_MAC : S_ROT;
                        end
                    end
                end
                S_MAC: begin
                    r_p_vld <= 1'b1;
                    if (t_end && c_end) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: r_state <= S_MUL;
                S_MUL:  r_state <= S_RND;
                S_RND:  r_state <= S_SAT;
                S_SAT:  r_state <= S_OUT;
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= f_end ? S_ROT : S_MAC;
                    end
                end
                S_ROT: begin
                    r_head <= r_head + TAP_W'(1);
                    if (r_realign && (r_head != TAP_W'(MAX_TAPS - 1))) begin
                        r_state <= S_ROT;
                    end else begin
                        r_realign <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_x <= $signed(cell_rd[tap_age[TAP_W-1:0]]);
        if (r_state == S_IDLE) begin
            r_f    <= '0;
            r_c    <= '0;
            r_t    <= '0;
            r_addr <= '0;
            r_acc  <= r_use_bias ? r_bias[0] : 32'd0;
        end else if (r_state == S_MAC) begin
            r_addr <= r_addr + W_AW'(1);
            if (t_end) begin
                r_t <= '0;
                r_c <= r_c + CH_W'(1);
            end else begin
                r_t <= r_t + TAP_W'(1);
            end
        end else if ((r_state == S_OUT) && i_out_ready && !f_end) begin
            r_f   <= r_f + F_W'(1);
            r_c   <= '0;
            r_t   <= '0;
            r_acc <= r_use_bias ? r_bias[r_f + F_W'(1)] : 32'd0;
        end
        if (r_p_vld && !(r_use_mask && !w_rdata[8])) begin
            r_acc <= r_acc + {{16{prod[15]}}, prod};
        end
        if (r_state == S_MUL) begin
            r_neg  <= r_acc[31];
            r_prod <= {31'd0, mag} * {32'd0, r_mult};
        end
        if (r_state == S_RND) begin
            r_sum <= r_prod + rnd;
        end
        if (r_state == S_SAT) begin
            r_out.out_value    <= sat;
            r_out.filter_index <= r_f;
            r_out.last_of_row  <= f_end;
        end
    end
endmodule

// File: src/i8cv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module i8cv_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/i8cv_row_cell.sv
// One cell of the row ring: holds one row of activations, takes a written
// sample, and hands its row to the next cell when the ring rotates.
// Depends on i8cv_pkg.
module i8cv_row_cell
    import i8cv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [CH_W-1:0] i_wr_ch,
    input  logic [7:0]      i_wr_data,
    input  logic            i_shift,
    input  t_row            i_row,
    input  logic [CH_W-1:0] i_rd_ch,
    output t_row            o_row,
    output logic [7:0]      o_rd
);
    t_row r_row;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_row <= i_row;
        end else if (i_wr_en) begin
            r_row[i_wr_ch] <= i_wr_data;
        end
    end

    assign o_row = r_row;
    assign o_rd  = r_row[i_rd_ch];
endmodule

// File: src/i8cv_checker.sv
// Port-level checker for the convolution core, bound to the top level.
// Depends on i8cv_pkg.
module i8cv_checker
    import i8cv_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // No result is pending right after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The core takes no new request while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    // A result is never valid right after an accepted request.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid)
        else $error("result too early after request");
endmodule

bind int8_conv1d_requant_masked_core i8cv_checker u_i8cv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
